@@ hw/rtl/sasd_pkg.sv @@
`timescale 1ns / 1ps
package sasd_pkg;

   localparam int ADDR_BITS     = 34;
   localparam int CORES         = 64;
   localparam int SHARER_W      = 64;
   localparam int ENTRY_W       = ADDR_BITS + SHARER_W + 1;
   localparam int COUNT_W       = $clog2(SHARER_W + 1);
   localparam int DEFAULT_SETS  = 1024;
   localparam int DEFAULT_WAYS  = 8;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 8;

   localparam logic [3:0] BLOCK_OFFSET_RESET = 4'd6;

   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACE_POLICY     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SKEW_ENABLE        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPECIAL_INTERLEAVE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_OFFSET_BITS  = 3'd3;

   localparam logic [2:0] KIND_LOOKUP    = 3'd0;
   localparam logic [2:0] KIND_SNOOP     = 3'd1;
   localparam logic [2:0] KIND_ADD       = 3'd2;
   localparam logic [2:0] KIND_ADD_EXCL  = 3'd3;
   localparam logic [2:0] KIND_REMOVE    = 3'd4;
   localparam logic [2:0] KIND_MAKE_EXCL = 3'd5;

   localparam logic [1:0] SHARE_NONE      = 2'd0;
   localparam logic [1:0] SHARE_SHARED    = 2'd1;
   localparam logic [1:0] SHARE_EXCLUSIVE = 2'd2;

   typedef struct packed {
      logic [2:0]           kind;
      logic [ADDR_BITS-1:0] line_address;
      logic [5:0]           requester;
      logic                 evict_request;
   } req_payload_type;

   typedef struct packed {
      logic                 hit;
      logic [SHARER_W-1:0]  sharer_bits;
      logic [1:0]           sharing_state;
      logic                 invalidate_valid;
      logic [ADDR_BITS-1:0] invalidate_tag;
      logic [SHARER_W-1:0]  invalidate_sharers;
   } rsp_payload_type;

   typedef struct packed {
      logic clear_en;
      logic accept;
      logic capture_row;
      logic eval_en;
      logic write_en;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
   } status_type;

endpackage

@@ hw/rtl/set_assoc_sharer_directory_core.sv @@
`timescale 1ns / 1ps
// Set-associative sharer directory. Each request reads one set row (all ways plus the
// recency order) from a single-port-write RAM, resolves hit and victim, writes the row
// back and places one result in an output register. A request passes through the steps
// accept/read, capture and compare, hit/victim select and write-back, shaped by the RAM's
// registered read and the write-back of the same row; the result is registered at the
// write-back edge. Requests are handled one at a time, so a new request is not taken until
// the previous one has been written back; a result still stalled at the output holds the
// next write-back until it drains. After reset the RAM is swept to its reset contents, one
// set per cycle, over all SETS sets (1024 by default); requests stall during the sweep,
// configuration writes are taken.
module set_assoc_sharer_directory_core #(
   parameter int SETS = sasd_pkg::DEFAULT_SETS,
   parameter int WAYS = sasd_pkg::DEFAULT_WAYS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  sasd_pkg::req_payload_type         req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output sasd_pkg::rsp_payload_type         rsp_payload,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sasd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sasd_pkg::CSR_DATA_W-1:0]   csr_data
);
   import sasd_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   sasd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sasd_datapath #(.SETS(SETS), .WAYS(WAYS)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

endmodule

@@ hw/rtl/sasd_ram.sv @@
`timescale 1ns / 1ps
module sasd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/sasd_ctrl.sv @@
`timescale 1ns / 1ps
module sasd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  sasd_pkg::status_type status,
   output sasd_pkg::cmd_type    cmd
);
   import sasd_pkg::*;

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_READ  = 5'b00100,
      S_EVAL  = 5'b01000,
      S_WRITE = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !(rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_READ;
            end
         end
         S_READ: begin
            cmd.capture_row = 1'b1;
            state_in        = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval_en = 1'b1;
            state_in    = S_WRITE;
         end
         S_WRITE: begin
            // hold until the output register can take the result
            if (out_free) begin
               cmd.write_en = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.write_en) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hw/rtl/sasd_datapath.sv @@
`timescale 1ns / 1ps
module sasd_datapath #(
   parameter int SETS = sasd_pkg::DEFAULT_SETS,
   parameter int WAYS = sasd_pkg::DEFAULT_WAYS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  sasd_pkg::cmd_type                      cmd,
   output sasd_pkg::status_type                   status,
   input  sasd_pkg::req_payload_type              req_payload,
   output sasd_pkg::rsp_payload_type              rsp_payload,
   input  logic                                   csr_write,
   input  logic [sasd_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [sasd_pkg::CSR_DATA_W-1:0]        csr_data
);
   import sasd_pkg::*;

   localparam int SET_AW  = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WB      = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ORDER_W = WAYS * WB;
   localparam int ROW_W   = WAYS * ENTRY_W + ORDER_W;
   localparam int NB      = $clog2(SETS + 1) - 1;
   localparam int SK      = (ADDR_BITS > NB) ? (ADDR_BITS - NB) : 0;
   localparam logic [ADDR_BITS-1:0] SET_MASK = ADDR_BITS'(SETS - 1);
   localparam logic [ADDR_BITS-1:0] M_LO2    = ADDR_BITS'(3);
   localparam logic [ADDR_BITS-1:0] M_B2     = ADDR_BITS'(4);
   localparam logic [ADDR_BITS-1:0] M_B6     = ADDR_BITS'(64);
   localparam logic [ADDR_BITS-1:0] M_B78    = ADDR_BITS'(12'h180);
   localparam logic [ADDR_BITS-1:0] M_LOW9   = ADDR_BITS'(12'h1FF);
   localparam logic [ADDR_BITS-1:0] M_B345   = ADDR_BITS'(8'h38);
   localparam logic [ADDR_BITS-1:0] M_LOW6   = ADDR_BITS'(8'h3F);

   // configuration
   logic       policy_ff, skew_ff, interleave_ff;
   logic [3:0] offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff     <= 1'b0;
         skew_ff       <= 1'b0;
         interleave_ff <= 1'b0;
         offset_ff     <= BLOCK_OFFSET_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_REPLACE_POLICY:     policy_ff     <= csr_data[0];
            CSR_SKEW_ENABLE:        skew_ff       <= csr_data[0];
            CSR_SPECIAL_INTERLEAVE: interleave_ff <= csr_data[0];
            CSR_BLOCK_OFFSET_BITS:  offset_ff     <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // set index
   logic [ADDR_BITS-1:0] idx, hi, bank, perm, set_full;
   logic [SET_AW-1:0]    set_index;

   always_comb begin
      idx  = req_payload.line_address >> offset_ff;
      hi   = req_payload.line_address >> SK;
      bank = (idx & M_LO2) | ((idx & M_B2) << 1) | ((idx & M_B6) >> 4) | ((idx & M_B78) >> 3);
      perm = (idx & ~M_LOW9) | ((idx & M_B345) << 3);
      if (interleave_ff) begin
         if (skew_ff) set_full = ((perm ^ (hi & ~M_LOW6)) | bank) & SET_MASK;
         else         set_full = (perm | bank) & SET_MASK;
      end else begin
         if (skew_ff) set_full = (idx ^ hi) & SET_MASK;
         else         set_full = idx & SET_MASK;
      end
      set_index = set_full[SET_AW-1:0];
   end

   // clearing sweep
   logic [SET_AW-1:0] clear_cnt_ff;
   logic [ROW_W-1:0]  reset_row;

   always_ff @(posedge clock) begin
      if (reset) clear_cnt_ff <= '0;
      else if (cmd.clear_en) clear_cnt_ff <= clear_cnt_ff + SET_AW'(1);
   end

   assign status.clear_last = (clear_cnt_ff == SET_AW'(SETS - 1));

   always_comb begin
      reset_row = '0;
      for (int p = 0; p < WAYS; p++) begin
         reset_row[WAYS*ENTRY_W + p*WB +: WB] = WB'(p);
      end
   end

   // request registers
   req_payload_type   req_ff;
   logic [SET_AW-1:0] set_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_payload;
         set_ff <= set_index;
      end
   end

   // memory
   logic [ROW_W-1:0]  rd_row, new_row, wr_row;
   logic [SET_AW-1:0] wr_addr;
   logic              wr_en;

   assign wr_en   = cmd.clear_en || cmd.write_en;
   assign wr_addr = cmd.clear_en ? clear_cnt_ff : set_ff;
   assign wr_row  = cmd.clear_en ? reset_row : new_row;

   sasd_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_row),
      .rd_en   (cmd.accept),
      .rd_addr (set_index),
      .rd_data (rd_row)
   );

   // row capture with per-way tag match and sharer counts
   logic [ROW_W-1:0]   row_ff;
   logic [WAYS-1:0]    match_ff, zero_ff;
   logic [COUNT_W-1:0] cnt_ff [WAYS];

   always_ff @(posedge clock) begin
      if (cmd.capture_row) begin
         row_ff <= rd_row;
         for (int w = 0; w < WAYS; w++) begin
            match_ff[w] <= (rd_row[w*ENTRY_W + SHARER_W + 1 +: ADDR_BITS] ==
                            req_ff.line_address);
            zero_ff[w]  <= (rd_row[w*ENTRY_W + 1 +: SHARER_W] == '0);
            cnt_ff[w]   <= COUNT_W'($countones(rd_row[w*ENTRY_W + 1 +: SHARER_W]));
         end
      end
   end

   logic [WB-1:0]        order_p [WAYS];
   logic [ADDR_BITS-1:0] tag_w   [WAYS];
   logic [SHARER_W-1:0]  shr_w   [WAYS];
   logic                 exc_w   [WAYS];

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         order_p[w] = row_ff[WAYS*ENTRY_W + w*WB +: WB];
         tag_w[w]   = row_ff[w*ENTRY_W + SHARER_W + 1 +: ADDR_BITS];
         shr_w[w]   = row_ff[w*ENTRY_W + 1 +: SHARER_W];
         exc_w[w]   = row_ff[w*ENTRY_W];
      end
   end

   // hit position and victim position, in recency order
   logic               hit_c, found_c;
   logic [WB-1:0]      hit_pos_c, vic_pos_c;
   logic [COUNT_W-1:0] min_c;
   logic               hit_ff;
   logic [WB-1:0]      pos_ff;

   always_comb begin
      hit_c     = 1'b0;
      hit_pos_c = '0;
      found_c   = 1'b0;
      vic_pos_c = '0;
      min_c     = '0;
      for (int p = 0; p < WAYS; p++) begin
         if (!hit_c && match_ff[order_p[p]]) begin
            hit_c     = 1'b1;
            hit_pos_c = WB'(p);
         end
         if (!policy_ff) begin
            if (zero_ff[order_p[p]]) begin
               found_c   = 1'b1;
               vic_pos_c = WB'(p);
            end
         end else if (!found_c || cnt_ff[order_p[p]] < min_c) begin
            found_c   = 1'b1;
            min_c     = cnt_ff[order_p[p]];
            vic_pos_c = WB'(p);
         end
      end
      if (!found_c) vic_pos_c = WB'(WAYS - 1);
   end

   always_ff @(posedge clock) begin
      if (cmd.eval_en) begin
         hit_ff <= hit_c;
         pos_ff <= hit_c ? hit_pos_c : vic_pos_c;
      end
   end

   // update of the selected entry and the recency order
   logic [WB-1:0]       way_sel;
   logic [SHARER_W-1:0] bit_c, shr_old, shr_new;
   logic                exc_old, exc_new, allocate, move_front;
   logic [1:0]          state_c;
   rsp_payload_type     rsp_c, rsp_ff;
   logic [2:0]          kind;

   always_comb begin
      kind     = req_ff.kind;
      way_sel  = order_p[pos_ff];
      shr_old  = shr_w[way_sel];
      exc_old  = exc_w[way_sel];
      bit_c    = ({1'b0, req_ff.requester} < 7'(CORES)) ?
                 (SHARER_W'(1) << req_ff.requester) : '0;
      allocate = !hit_ff && (kind == KIND_LOOKUP);
      move_front = (kind == KIND_LOOKUP) && !req_ff.evict_request && (hit_ff || allocate);

      shr_new = shr_old;
      exc_new = exc_old;
      if (kind == KIND_ADD || kind == KIND_ADD_EXCL) begin
         shr_new = shr_new | bit_c;
         if (shr_new != bit_c) exc_new = 1'b0;
      end
      if ((kind == KIND_ADD_EXCL || kind == KIND_MAKE_EXCL) && bit_c != '0) begin
         shr_new = bit_c;
         exc_new = 1'b1;
      end
      if (kind == KIND_REMOVE) begin
         shr_new = shr_new & ~bit_c;
         if (shr_new == '0) exc_new = 1'b0;
      end
      if (shr_new == '0)  state_c = SHARE_NONE;
      else if (exc_new)   state_c = SHARE_EXCLUSIVE;
      else                state_c = SHARE_SHARED;

      new_row = row_ff;
      for (int w = 0; w < WAYS; w++) begin
         if (WB'(w) == way_sel) begin
            if (hit_ff) begin
               new_row[w*ENTRY_W + 1 +: SHARER_W] = shr_new;
               new_row[w*ENTRY_W]                 = exc_new;
            end else if (allocate) begin
               new_row[w*ENTRY_W +: ENTRY_W] = {req_ff.line_address, {SHARER_W{1'b0}}, 1'b0};
            end
         end
      end
      if (move_front) begin
         for (int p = 0; p < WAYS; p++) begin
            if (p == 0) new_row[WAYS*ENTRY_W +: WB] = way_sel;
            else if (WB'(p) <= pos_ff)
               new_row[WAYS*ENTRY_W + p*WB +: WB] = order_p[p-1];
         end
      end

      rsp_c = '0;
      if (hit_ff) begin
         rsp_c.hit           = 1'b1;
         rsp_c.sharer_bits   = shr_new;
         rsp_c.sharing_state = state_c;
      end else if (allocate) begin
         rsp_c.invalidate_valid   = 1'b1;
         rsp_c.invalidate_tag     = tag_w[way_sel];
         rsp_c.invalidate_sharers = shr_old;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_en) rsp_ff <= rsp_c;
   end

   assign rsp_payload = rsp_ff;

endmodule

@@ verif/set_assoc_sharer_directory_core_tb.sv @@
`timescale 1ns / 1ps
module set_assoc_sharer_directory_core_tb;
   import sasd_pkg::*;

   localparam int NUM_SETS    = DEFAULT_SETS;
   localparam int NUM_WAYS    = DEFAULT_WAYS;
   localparam int CYCLE_LIMIT = 400000;
   localparam int NUM_PHASES  = 6;
   localparam int PHASE_ITEMS = 225;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 3'd5;
   localparam logic [ADDR_BITS-1:0]   ADDR_ONES = '1;

   class directory_mirror;
      logic [ADDR_BITS-1:0] tag_mem [NUM_SETS*NUM_WAYS];
      logic [SHARER_W-1:0]  sharer_mem [NUM_SETS*NUM_WAYS];
      logic                 excl_mem [NUM_SETS*NUM_WAYS];
      logic [2:0]           order_mem [NUM_SETS][NUM_WAYS];
      logic                 policy_fewest, skew_on, interleave_on;
      logic [3:0]           offset_bits;
      rsp_payload_type      pending_rsp [$];
      int                   mismatches;

      function new();
         for (int i = 0; i < NUM_SETS*NUM_WAYS; i++) begin
            tag_mem[i] = '0;
            sharer_mem[i] = '0;
            excl_mem[i] = 1'b0;
         end
         for (int s = 0; s < NUM_SETS; s++)
            for (int w = 0; w < NUM_WAYS; w++) order_mem[s][w] = 3'(w);
         policy_fewest = 0;
         skew_on = 0;
         interleave_on = 0;
         offset_bits = BLOCK_OFFSET_RESET;
         mismatches = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_REPLACE_POLICY:     policy_fewest = data[0];
            CSR_SKEW_ENABLE:        skew_on = data[0];
            CSR_SPECIAL_INTERLEAVE: interleave_on = data[0];
            CSR_BLOCK_OFFSET_BITS:  offset_bits = data[3:0];
            default: ;
         endcase
      endfunction

      function int set_of(logic [ADDR_BITS-1:0] addr);
         logic [63:0] idx, hi, bank, s, r;
         idx = 64'(addr) >> offset_bits;
         hi = 64'(addr) >> (ADDR_BITS - 10);
         if (interleave_on) begin
            bank = (idx & 64'h3) | ((idx & 64'h4) << 1) | ((idx & 64'h40) >> 4)
                 | ((idx & 64'h180) >> 3);
            s = (idx & ~64'h1FF) | ((idx & 64'h38) << 3);
            r = skew_on ? ((s ^ (hi & ~64'h3F)) | bank) : (s | bank);
         end else begin
            r = skew_on ? (idx ^ hi) : idx;
         end
         return int'(r & 64'(NUM_SETS - 1));
      endfunction

      function void promote(int set, int pos);
         logic [2:0] w;
         w = order_mem[set][pos];
         for (int q = pos; q > 0; q--) order_mem[set][q] = order_mem[set][q-1];
         order_mem[set][0] = w;
      endfunction

      function void note_request(req_payload_type r);
         int set, base, pos, e, best, min_cnt, cnt;
         logic found;
         logic [SHARER_W-1:0] bit_m;
         rsp_payload_type x;
         set = set_of(r.line_address);
         base = set * NUM_WAYS;
         pos = -1;
         for (int p = 0; p < NUM_WAYS; p++)
            if (pos < 0 && tag_mem[base + order_mem[set][p]] == r.line_address) pos = p;
         bit_m = 64'd1 << r.requester;
         x = '0;
         if (pos >= 0) begin
            x.hit = 1'b1;
            e = base + order_mem[set][pos];
            if (r.kind == KIND_LOOKUP && !r.evict_request) promote(set, pos);
            if (r.kind == KIND_ADD || r.kind == KIND_ADD_EXCL) begin
               sharer_mem[e] |= bit_m;
               if (sharer_mem[e] != bit_m) excl_mem[e] = 1'b0;
            end
            if (r.kind == KIND_ADD_EXCL || r.kind == KIND_MAKE_EXCL) begin
               sharer_mem[e] = bit_m;
               excl_mem[e] = 1'b1;
            end
            if (r.kind == KIND_REMOVE) begin
               sharer_mem[e] &= ~bit_m;
               if (sharer_mem[e] == '0) excl_mem[e] = 1'b0;
            end
            x.sharer_bits = sharer_mem[e];
            x.sharing_state = (sharer_mem[e] == '0) ? SHARE_NONE :
                              (excl_mem[e] ? SHARE_EXCLUSIVE : SHARE_SHARED);
         end else if (r.kind == KIND_LOOKUP) begin
            found = 1'b0;
            best = 0;
            min_cnt = 1000;
            for (int p = 0; p < NUM_WAYS; p++) begin
               cnt = $countones(sharer_mem[base + order_mem[set][p]]);
               if (!policy_fewest) begin
                  if (cnt == 0) begin
                     best = p;
                     found = 1'b1;
                  end
               end else if (cnt < min_cnt) begin
                  min_cnt = cnt;
                  best = p;
                  found = 1'b1;
               end
            end
            if (!found) best = NUM_WAYS - 1;
            e = base + order_mem[set][best];
            if (!r.evict_request) promote(set, best);
            x.invalidate_valid = 1'b1;
            x.invalidate_tag = tag_mem[e];
            x.invalidate_sharers = sharer_mem[e];
            tag_mem[e] = r.line_address;
            sharer_mem[e] = '0;
            excl_mem[e] = 1'b0;
         end
         pending_rsp = {pending_rsp, x};
      endfunction

      function void compare(string name, logic [63:0] exp_v, logic [63:0] act_v);
         if (exp_v !== act_v) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch %s: expected %h, got %h", name, exp_v, act_v);
         end
      endfunction

      function void check_response(rsp_payload_type a);
         rsp_payload_type x;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", a);
            return;
         end
         x = pending_rsp.pop_front();
         compare("hit", 64'(x.hit), 64'(a.hit));
         compare("sharer_bits", x.sharer_bits, a.sharer_bits);
         compare("sharing_state", 64'(x.sharing_state), 64'(a.sharing_state));
         compare("invalidate_valid", 64'(x.invalidate_valid), 64'(a.invalidate_valid));
         compare("invalidate_tag", 64'(x.invalidate_tag), 64'(a.invalidate_tag));
         compare("invalidate_sharers", x.invalidate_sharers, a.invalidate_sharers);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   directory_mirror mirror = new();
   logic quiet = 1'b0;
   int cycle_count = 0;
   int stall_left = 0;
   logic [ADDR_BITS-1:0] addr_pool [12];

   set_assoc_sharer_directory_core #(.SETS(NUM_SETS), .WAYS(NUM_WAYS)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver: random stall bursts, none once quiet
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) mirror.check_response(rsp_payload);
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 10);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send(req_payload_type p);
      req_valid <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (req_stall);
      mirror.note_request(p);
   endtask

   task automatic hold_off(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      mirror.write_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (mirror.pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic req_payload_type make_req(logic [2:0] k, logic [ADDR_BITS-1:0] a,
                                                 logic [5:0] who, logic ev);
      req_payload_type p;
      p.kind = k;
      p.line_address = a;
      p.requester = who;
      p.evict_request = ev;
      return p;
   endfunction

   function automatic logic [ADDR_BITS-1:0] rand_addr();
      return ADDR_BITS'({$urandom, $urandom});
   endfunction

   // addresses that share index bits, so sets fill up and evict
   function automatic void build_pool(logic [3:0] ofs);
      logic [63:0] mid_mask, full_mask, base;
      base = 64'(rand_addr());
      mid_mask = 64'h3FF << ofs;
      full_mask = mid_mask | (64'h3FF << (ADDR_BITS - 10));
      for (int i = 0; i < 12; i++)
         addr_pool[i] = ADDR_BITS'((64'(rand_addr()) & ~((i % 2) ? full_mask : mid_mask))
                                   | (base & ((i % 2) ? full_mask : mid_mask)));
   endfunction

   function automatic req_payload_type random_req();
      int roll;
      logic [2:0] k;
      logic [ADDR_BITS-1:0] a;
      roll = $urandom_range(0, 99);
      if (roll < 35) k = KIND_LOOKUP;
      else if (roll < 45) k = KIND_SNOOP;
      else if (roll < 65) k = KIND_ADD;
      else if (roll < 75) k = KIND_ADD_EXCL;
      else if (roll < 87) k = KIND_REMOVE;
      else if (roll < 95) k = KIND_MAKE_EXCL;
      else k = 3'($urandom_range(6, 7));
      case ($urandom_range(0, 19))
         0: a = '0;
         1: a = ADDR_ONES;
         2, 3: a = rand_addr();
         default: a = addr_pool[$urandom_range(0, 11)];
      endcase
      return make_req(k, a, 6'($urandom_range(0, 63)), $urandom_range(0, 4) == 0);
   endfunction

   initial begin
      logic [CSR_DATA_W-1:0] d;
      logic [ADDR_BITS-1:0] a1;
      logic pol_v [NUM_PHASES] = '{0, 1, 0, 1, 0, 1};
      logic skw_v [NUM_PHASES] = '{0, 1, 1, 0, 0, 1};
      logic ilv_v [NUM_PHASES] = '{0, 1, 0, 1, 1, 0};
      logic [3:0] ofs_v [NUM_PHASES] = '{6, 0, 12, 3, 12, 0};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset entries, every kind, sharer edge cases
      a1 = rand_addr();
      send(make_req(KIND_LOOKUP, '0, 6'd0, 1'b0));
      send(make_req(KIND_ADD, '0, 6'd0, 1'b0));
      send(make_req(KIND_ADD, '0, 6'd63, 1'b0));
      send(make_req(KIND_ADD_EXCL, '0, 6'd5, 1'b0));
      send(make_req(KIND_ADD, '0, 6'd5, 1'b0));
      send(make_req(KIND_MAKE_EXCL, '0, 6'd63, 1'b0));
      send(make_req(KIND_REMOVE, '0, 6'd63, 1'b0));
      send(make_req(KIND_SNOOP, '0, 6'd1, 1'b1));
      send(make_req(3'd6, '0, 6'd2, 1'b0));
      send(make_req(3'd7, ADDR_ONES, 6'd2, 1'b1));
      send(make_req(KIND_SNOOP, a1, 6'd3, 1'b0));
      send(make_req(KIND_ADD, a1, 6'd3, 1'b0));
      send(make_req(KIND_REMOVE, a1, 6'd3, 1'b0));
      send(make_req(KIND_LOOKUP, ADDR_ONES, 6'd63, 1'b0));
      send(make_req(KIND_ADD, ADDR_ONES, 6'd63, 1'b0));
      send(make_req(KIND_LOOKUP, ADDR_ONES, 6'd0, 1'b1));
      for (int i = 1; i <= 9; i++)
         send(make_req(KIND_LOOKUP, ADDR_ONES ^ ADDR_BITS'(i << 16), 6'(i), i == 9));
      drain();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         quiet = (ph == NUM_PHASES - 1);
         d = 8'($urandom); d[0] = pol_v[ph]; csr_write(CSR_REPLACE_POLICY, d);
         d = 8'($urandom); d[0] = skw_v[ph]; csr_write(CSR_SKEW_ENABLE, d);
         d = 8'($urandom); d[0] = ilv_v[ph]; csr_write(CSR_SPECIAL_INTERLEAVE, d);
         d = 8'($urandom); d[3:0] = ofs_v[ph]; csr_write(CSR_BLOCK_OFFSET_BITS, d);
         if (ph == 1) csr_write(CSR_UNUSED_INDEX, 8'($urandom));
         build_pool(ofs_v[ph]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 40 == 39) build_pool(ofs_v[ph]);
            send(random_req());
            if (!quiet && $urandom_range(0, 7) == 0) hold_off($urandom_range(1, 11));
         end
         drain();
      end

      if (mirror.mismatches == 0 && mirror.pending_rsp.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
